@@ rtl/core/adts_pkg.sv @@
// shared types, constants and the sample rate table for the adts deframer
`default_nettype none

package adts_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0] SYNC_HI   = 8'hFF;
  localparam logic [3:0] SYNC_LO   = 4'hF;
  localparam logic [12:0] HDR_LEN  = 13'd7;
  localparam logic [2:0] HDR_LAST  = 3'd6;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SYNC = 2'd1,
    ST_SHORT    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_HALT   = 2'd2
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] offset;
    logic [12:0] length;
    logic [3:0]  rate_idx;
    logic [2:0]  chan;
    logic [31:0] number;
  } hdr_entry_t;

  function automatic logic [16:0] rate_of(input logic [3:0] idx);
    logic [16:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/adts_frame_deframer.sv @@
// top level of the adts frame deframer
//
// usage: raw adts stream bytes enter on the s_ side, one byte per beat.
// for every frame header (seven bytes) one result beat leaves on the m_
// side, carrying status, frame offset, length, sample rate in hz, channel
// configuration, frame number and largest frame length so far.
// payload bytes after a header are counted and dropped.
// throughput: one byte per cycle while the queue is not full; the front end
// decodes on the fly and pushes each header into a four-entry queue.
// a header is written into the queue at the edge that takes the seventh
// header byte, and moves from there into the output register once it is free.
// a bad sync word or a length below seven gives an error beat, after which
// bytes are still taken but ignored until reset.
// receiver stall: results wait in the output register and the queue; once
// the queue is full, s_tready drops until the receiver takes a beat.
// reset (rst, synchronous, active high) clears counters, queue and output.
`default_nettype none

module adts_frame_deframer import adts_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // data_byte
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [111:0]      m_tdata    // status, frame_offset, frame_length,
                                       // sample_rate_hz, channel_config,
                                       // frame_number, max_frame_length
);

  hdr_entry_t wr_entry;
  hdr_entry_t rd_entry;
  logic       push;
  logic       pop;
  logic       full;
  logic       not_empty;

  assign s_tready = !full;

  adts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (s_tvalid && s_tready),
    .data_byte (s_tdata),
    .entry     (wr_entry),
    .push      (push)
  );

  adts_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .rd_entry  (rd_entry),
    .full      (full),
    .not_empty (not_empty)
  );

  adts_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (rd_entry),
    .entry_valid (not_empty),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/core/adts_front.sv @@
// byte front end: header collection, sync and length check, frame skipping
`default_nettype none

module adts_front import adts_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] data_byte,
  output hdr_entry_t      entry,
  output logic            push
);

  phase_t      phase;
  logic [47:0] header_shift;
  logic [2:0]  header_pos;
  logic [12:0] skip_left;
  logic [31:0] byte_position;
  logic [31:0] frame_start;
  logic [31:0] frame_count;

  logic [7:0]  b0, b1, b2, b3, b4, b5;
  logic [12:0] len;
  logic [12:0] skip_next;
  status_t     status;
  logic        last_hdr;
  logic        active;

  assign b0 = header_shift[47:40];
  assign b1 = header_shift[39:32];
  assign b2 = header_shift[31:24];
  assign b3 = header_shift[23:16];
  assign b4 = header_shift[15:8];
  assign b5 = header_shift[7:0];
  assign len = {b3[1:0], b4, b5[7:5]};

  always_comb begin
    if (b0 != SYNC_HI || b1[7:4] != SYNC_LO) begin
      status = ST_BAD_SYNC;
    end else if (len < HDR_LEN) begin
      status = ST_SHORT;
    end else begin
      status = ST_OK;
    end
  end

  assign active    = take && (phase == PH_HEADER || phase == PH_SKIP);
  assign last_hdr  = active && phase == PH_HEADER && header_pos == HDR_LAST;
  assign skip_next = skip_left - 13'd1;
  assign push      = last_hdr;

  always_comb begin
    entry.status   = status;
    entry.offset   = frame_start;
    entry.length   = len;
    entry.rate_idx = b2[5:2];
    entry.chan     = {b2[0], b3[7:6]};
    entry.number   = frame_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_shift  <= '0;
      header_pos    <= '0;
      skip_left     <= '0;
      byte_position <= '0;
      frame_start   <= '0;
      frame_count   <= '0;
    end else if (active) begin
      byte_position <= byte_position + 32'd1;
      if (phase == PH_SKIP) begin
        skip_left <= skip_next;
        if (skip_next == 13'd0) begin
          phase <= PH_HEADER;
        end
      end else if (header_pos != HDR_LAST) begin
        if (header_pos == 3'd0) begin
          frame_start <= byte_position;
        end
        header_shift <= {header_shift[39:0], data_byte};
        header_pos   <= header_pos + 3'd1;
      end else begin
        header_pos   <= '0;
        header_shift <= '0;
        if (status != ST_OK) begin
          phase <= PH_HALT;
        end else begin
          frame_count <= frame_count + 32'd1;
          skip_left   <= len - HDR_LEN;
          phase       <= (len != HDR_LEN) ? PH_SKIP : PH_HEADER;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/adts_fifo.sv @@
// short queue of decoded headers between front and back end
`default_nettype none

module adts_fifo import adts_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire hdr_entry_t wr_entry,
  input  wire logic pop,
  output hdr_entry_t rd_entry,
  output logic      full,
  output logic      not_empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  hdr_entry_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = count == FULL_CNT;
  assign not_empty = count != '0;
  assign rd_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/adts_back.sv @@
// back end: rate lookup, running maximum and registered result beat
`default_nettype none

module adts_back import adts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire hdr_entry_t entry,
  input  wire logic     entry_valid,
  output logic          pop,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  output logic [111:0]  m_tdata
);

  logic [12:0] largest;
  logic [12:0] max_next;
  logic        ok;
  logic [12:0] out_len;
  logic [16:0] out_rate;
  logic [2:0]  out_chan;
  logic [12:0] out_max;

  assign pop      = entry_valid && (!m_tvalid || m_tready);
  assign ok       = entry.status == ST_OK;
  assign max_next = (entry.length > largest) ? entry.length : largest;
  assign out_len  = ok ? entry.length : '0;
  assign out_rate = ok ? rate_of(entry.rate_idx) : '0;
  assign out_chan = ok ? entry.chan : '0;
  assign out_max  = ok ? max_next : largest;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      largest  <= '0;
    end else begin
      if (pop) begin
        m_tvalid <= 1'b1;
        if (ok) begin
          largest <= max_next;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {out_max, entry.number, out_chan, out_rate, out_len, entry.offset,
                  entry.status};
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_adts_frame_deframer.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the adts frame deframer: random streams against a predictor

module tb import adts_pkg::*;;

  typedef struct {
    status_t     status;
    logic [31:0] offset;
    logic [12:0] length;
    logic [16:0] rate_hz;
    logic [2:0]  chan;
    logic [31:0] number;
    logic [12:0] longest;
  } frame_rec_t;

  class header_scoreboard;
    phase_t      mode;
    logic [47:0] hdr_bytes;
    logic [2:0]  hdr_cnt;
    logic [12:0] payload_left;
    logic [31:0] stream_pos;
    logic [31:0] cur_start;
    logic [31:0] frames_seen;
    logic [12:0] longest;
    frame_rec_t  pending_headers[$];
    int          mismatches;

    function new();
      mode         = PH_HEADER;
      hdr_bytes    = '0;
      hdr_cnt      = '0;
      payload_left = '0;
      stream_pos   = '0;
      cur_start    = '0;
      frames_seen  = '0;
      longest      = '0;
      mismatches   = 0;
    endfunction

    function int outstanding();
      return pending_headers.size();
    endfunction

    function logic [16:0] hz_of(logic [3:0] idx);
      logic [16:0] hz [13];
      hz = '{17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
             17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000, 17'd7350};
      if (idx < 4'd13) begin
        return hz[idx];
      end
      return 17'd0;
    endfunction

    // advance the header predictor by one stream byte
    function void take_byte(logic [7:0] b);
      frame_rec_t  e;
      logic [12:0] len;
      logic [7:0]  h0, h1, h2, h3, h4, h5;
      if (mode != PH_HEADER && mode != PH_SKIP) begin
        return;
      end
      if (mode == PH_SKIP) begin
        stream_pos++;
        payload_left = payload_left - 13'd1;
        if (payload_left == 13'd0) begin
          mode = PH_HEADER;
        end
        return;
      end
      if (hdr_cnt == 3'd0) begin
        cur_start = stream_pos;
      end
      stream_pos++;
      if (hdr_cnt < HDR_LAST) begin
        hdr_bytes = {hdr_bytes[39:0], b};
        hdr_cnt++;
        return;
      end
      {h0, h1, h2, h3, h4, h5} = hdr_bytes;
      hdr_cnt   = '0;
      hdr_bytes = '0;
      len       = {h3[1:0], h4, h5[7:5]};
      e.offset  = cur_start;
      e.number  = frames_seen;
      e.length  = '0;
      e.rate_hz = '0;
      e.chan    = '0;
      if (h0 != SYNC_HI || h1[7:4] != SYNC_LO) begin
        e.status = ST_BAD_SYNC;
      end else if (len < HDR_LEN) begin
        e.status = ST_SHORT;
      end else begin
        e.status = ST_OK;
      end
      if (e.status != ST_OK) begin
        mode = PH_HALT;
      end else begin
        if (len > longest) begin
          longest = len;
        end
        frames_seen++;
        payload_left = len - HDR_LEN;
        mode         = (payload_left != 13'd0) ? PH_SKIP : PH_HEADER;
        e.length     = len;
        e.rate_hz    = hz_of(h2[5:2]);
        e.chan       = {h2[0], h3[7:6]};
      end
      e.longest = longest;
      pending_headers.push_back(e);
    endfunction

    task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_header(logic [111:0] d);
      frame_rec_t got, want;
      got.status  = status_t'(d[1:0]);
      got.offset  = d[33:2];
      got.length  = d[46:34];
      got.rate_hz = d[63:47];
      got.chan    = d[66:64];
      got.number  = d[98:67];
      got.longest = d[111:99];
      if (pending_headers.size() == 0) begin
        flag_mismatch("result beat with none pending", {30'd0, d[1:0]}, 32'd0);
        return;
      end
      want = pending_headers.pop_front();
      if (got.status !== want.status) begin
        flag_mismatch("status", 32'(got.status), 32'(want.status));
      end
      if (got.offset !== want.offset) flag_mismatch("frame_offset", got.offset, want.offset);
      if (got.length !== want.length) begin
        flag_mismatch("frame_length", 32'(got.length), 32'(want.length));
      end
      if (got.rate_hz !== want.rate_hz) begin
        flag_mismatch("sample_rate_hz", 32'(got.rate_hz), 32'(want.rate_hz));
      end
      if (got.chan !== want.chan) begin
        flag_mismatch("channel_config", 32'(got.chan), 32'(want.chan));
      end
      if (got.number !== want.number) flag_mismatch("frame_number", got.number, want.number);
      if (got.longest !== want.longest) begin
        flag_mismatch("max_frame_length", 32'(got.longest), 32'(want.longest));
      end
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;

  header_scoreboard sb;
  int bytes_sent = 0;
  bit tx_steady = 1'b0;
  int rx_hold = 0;
  bit rx_steady = 1'b0;

  adts_frame_deframer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("FAIL adts_frame_deframer");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.take_byte(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_header(m_tdata);
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) begin
      rx_steady = ~rx_steady;
    end
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_tready <= 1'b1;
      if (!rx_steady) begin
        rx_hold = idle_len();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [7:0] h0, input logic [3:0] h1_hi,
                             input logic [3:0] idx, input logic [2:0] ch,
                             input logic [12:0] len);
    logic [7:0] r;
    r = 8'($urandom);
    send_byte(h0);
    send_byte({h1_hi, r[3:0]});
    send_byte({r[7:6], idx, r[5], ch[2]});
    r = 8'($urandom);
    send_byte({ch[1:0], r[3:0], len[12:11]});
    send_byte(len[10:3]);
    send_byte({len[2:0], r[7:4], r[0]});
    send_byte(8'($urandom));
  endtask

  task automatic send_frame(input logic [3:0] idx, input logic [2:0] ch,
                            input logic [12:0] len);
    tx_steady = ($urandom_range(0, 3) == 0);
    send_header(SYNC_HI, SYNC_LO, idx, ch, len);
    repeat (len - HDR_LEN) send_byte(8'($urandom));
  endtask

  task automatic random_frame();
    logic [12:0] len;
    int r;
    r = int'($urandom_range(0, 9));
    if (r < 3) begin
      len = HDR_LEN;
    end else if (r < 8) begin
      len = 13'($urandom_range(8, 40));
    end else begin
      len = 13'($urandom_range(41, 300));
    end
    send_frame(4'($urandom), 3'($urandom), len);
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // end of stream: bad sync, short length, both, or a cut-off header
  task automatic stream_tail();
    int kind;
    logic [7:0]  h0;
    logic [3:0]  h1_hi;
    logic [12:0] len;
    kind  = int'($urandom_range(0, 3));
    h0    = SYNC_HI;
    h1_hi = SYNC_LO;
    len   = 13'($urandom_range(7, 8191));
    tx_steady = 1'b0;
    if (kind == 3) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    end else begin
      if (kind != 1) begin
        if ($urandom_range(0, 1) == 1) h0 = 8'($urandom_range(0, 254));
        else h1_hi = 4'($urandom_range(0, 14));
      end
      if (kind != 0) len = 13'($urandom_range(0, 6));
      send_header(h0, h1_hi, 4'($urandom), 3'($urandom), len);
      // halted: a clean frame after the fault must be ignored
      send_frame(4'($urandom), 3'($urandom), 13'd12);
    end
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_frame(4'd0, 3'd0, HDR_LEN);
    send_frame(4'd12, 3'd7, HDR_LEN);
    send_frame(4'd15, 3'd5, HDR_LEN);
    send_frame(4'($urandom_range(0, 12)), 3'($urandom), 13'($urandom_range(200, 400)));

    while (bytes_sent < 1550) begin
      random_frame();
      if (!paused && bytes_sent > 700) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
    stream_tail();

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS adts_frame_deframer");
    end else begin
      $display("FAIL adts_frame_deframer");
    end
    $finish;
  end
endmodule
